[rtl/core/fssm_pkg.sv]
// Package for the frame stream statistics monitor: field widths, payload and
// control structs. No dependencies.
package fssm_pkg;
  localparam int FIDW = 12;
  localparam int TW   = 32;
  localparam int GW   = 33;

  // one input word
  typedef struct packed {
    logic            req_type;
    logic [FIDW-1:0] seq_id;
    logic [TW-1:0]   arrival_us;
    logic            crc_ok;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic [31:0] delivered_count;
    logic [12:0] unique_count;
    logic [12:0] lost_count;
    logic [31:0] corrupt_count;
    logic [31:0] duplicate_count;
    logic [31:0] reordered_count;
    logic [31:0] duration_us;
    logic [31:0] fps_q8;
    logic [13:0] loss_basis_points;
    logic [32:0] jitter_us;
  } out_word_t;

  // request type codes
  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_SNAP  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic clr_step;    // clear one bitmap bit
    logic frm_rd;      // read bitmap bit for the frame
    logic frm_upd;     // apply frame update
    logic snap_init;   // start snapshot, latch fixed figures
    logic sum_step;    // accumulate one gap into S
    logic dev_start;   // start deviation pass
    logic dev_step;    // accumulate one |n*g - S|
    logic div_start;   // launch the three divisions
    logic out_load;    // load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic pipe_idle;   // pipeline of the walk drained
  } sts_t;
endpackage

[rtl/core/fssm_if.sv]
// Valid/ready stream channel interfaces for the statistics monitor.
// Depends on fssm_pkg.
interface fssm_in_if;
  logic              valid;
  logic              ready;
  fssm_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fssm_out_if;
  logic               valid;
  logic               ready;
  fssm_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/fssm_div.sv]
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// Depends on nothing.
module fssm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  logic [64:0] rem;
  logic [63:0] quo;
  logic [63:0] dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] trial;

  assign trial = {rem[63:0], quo[63]} - {1'b0, dvs};

  // shift-subtract loop
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 7'd64;
      rem  <= '0;
      quo  <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      if (!trial[64]) begin
        rem <= trial;
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= {rem[63:0], quo[63]};
        quo <= {quo[62:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end

  assign done     = !busy;
  assign quotient = quo;
endmodule

[rtl/core/fssm_dp.sv]
// Datapath: counters, seen bitmap memory, gap ring memory, accumulators and
// dividers. Depends on fssm_pkg and fssm_div.
module fssm_dp #(
  parameter int ID_BITS   = 12,
  parameter int GAP_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  fssm_pkg::cmd_t      cmd,
  output fssm_pkg::sts_t      sts,
  input  fssm_pkg::in_word_t  in_word,
  input  logic [6:0]          gap_window,
  output fssm_pkg::out_word_t result
);
  localparam int IDS = 1 << ID_BITS;
  localparam int HW  = (GAP_DEPTH > 1) ? $clog2(GAP_DEPTH) : 1;
  localparam int FW  = $clog2(GAP_DEPTH + 1);

  // bitmap memory, one bit per id, cleared by a sweep after reset
  logic             bitmap [IDS];
  logic [ID_BITS:0] clr_cnt;
  logic             seen_bit;
  logic [ID_BITS-1:0] fid;
  assign fid = ID_BITS'(in_word.seq_id);

  always_ff @(posedge clk) begin
    if (cmd.clr_step) bitmap[clr_cnt[ID_BITS-1:0]] <= 1'b0;
    else if (cmd.frm_upd) bitmap[fid] <= 1'b1;
    if (cmd.frm_rd) seen_bit <= bitmap[fid];
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clr_step) clr_cnt <= clr_cnt + 1'b1;
  end
  assign sts.clr_done = clr_cnt[ID_BITS];

  // frame state
  logic [31:0] delivered, corrupt, duplicate, reordered;
  logic [12:0] unique_n;
  logic        any_seen;
  logic [ID_BITS-1:0] base_id, high_id, prev_id;
  logic [31:0] first_t, last_t;
  logic [FW-1:0] gap_fill;
  logic [HW-1:0] gap_head;
  logic [FW-1:0] win;

  always_comb begin
    win = (gap_window == 7'd0) ? FW'(1) : FW'(gap_window);
    if (int'(gap_window) > GAP_DEPTH) win = FW'(GAP_DEPTH);
    if (gap_window == 7'd0) win = FW'(1);
  end

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  // gap ring memory
  logic signed [32:0] ring [GAP_DEPTH];
  logic signed [32:0] ring_rd;
  logic [HW-1:0]      rd_idx;
  logic [FW-1:0]      walk_cnt;
  logic               rd_vld;

  always_ff @(posedge clk) begin
    if (cmd.frm_upd && any_seen)
      ring[gap_head] <= $signed({1'b0, in_word.arrival_us}) - $signed({1'b0, last_t});
    ring_rd <= ring[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delivered <= '0; corrupt <= '0; duplicate <= '0; reordered <= '0;
      unique_n <= '0; any_seen <= 1'b0; base_id <= '0; high_id <= '0;
      prev_id <= '0; first_t <= '0; last_t <= '0; gap_fill <= '0;
      gap_head <= '0;
    end else if (cmd.frm_upd) begin
      delivered <= sat_inc(delivered);
      if (!in_word.crc_ok) corrupt <= sat_inc(corrupt);
      if (!any_seen) begin
        base_id <= fid;
        high_id <= fid;
        first_t <= in_word.arrival_us;
      end else begin
        if (fid < prev_id) reordered <= sat_inc(reordered);
        if (fid > high_id) high_id <= fid;
        gap_head <= (GAP_DEPTH > 1 && 32'(gap_head) != GAP_DEPTH - 1) ? gap_head + 1'b1 : '0;
        gap_fill <= (gap_fill >= win) ? win : gap_fill + 1'b1;
      end
      if (seen_bit) duplicate <= sat_inc(duplicate);
      else unique_n <= unique_n + 13'd1;
      prev_id  <= fid;
      last_t   <= in_word.arrival_us;
      any_seen <= 1'b1;
    end
  end

  // window walk: address generator, one read per cycle, newest first
  logic signed [43:0] sum_s;
  logic [55:0]        dev_acc;
  logic [FW-1:0]      n_lat;
  logic               walking;
  logic               prod_vld;
  logic signed [47:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      walking <= 1'b0;
      rd_vld  <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      rd_vld   <= walking;
      prod_vld <= rd_vld && cmd.dev_step;
      if (cmd.snap_init || cmd.dev_start) begin
        walking  <= (gap_fill != '0);
        walk_cnt <= gap_fill;
        rd_idx   <= (gap_head == '0) ? HW'(GAP_DEPTH - 1) : gap_head - 1'b1;
      end else if (walking) begin
        rd_idx   <= (rd_idx == '0) ? HW'(GAP_DEPTH - 1) : rd_idx - 1'b1;
        walk_cnt <= walk_cnt - 1'b1;
        if (walk_cnt == FW'(1)) walking <= 1'b0;
      end
    end
  end
  assign sts.pipe_idle = !walking && !rd_vld && !prod_vld;

  // sum and absolute deviation accumulators
  always_ff @(posedge clk) begin
    if (cmd.snap_init) begin
      sum_s   <= '0;
      dev_acc <= '0;
      n_lat   <= gap_fill;
    end else begin
      if (cmd.sum_step && rd_vld) sum_s <= sum_s + 44'(ring_rd);
      if (cmd.dev_step && rd_vld)
        prod <= $signed({1'b0, n_lat}) * ring_rd - 48'(sum_s);
      if (prod_vld) dev_acc <= dev_acc + 56'(prod[47] ? -prod : prod);
    end
  end

  // fixed figures latched at snapshot start
  logic [12:0] expected, lost;
  logic [31:0] dur;
  always_ff @(posedge clk) begin
    if (cmd.snap_init) begin
      if (any_seen) begin
        expected <= 13'(high_id - base_id) + 13'd1;
        lost <= (13'(high_id - base_id) + 13'd1 > unique_n) ?
                13'(high_id - base_id) + 13'd1 - unique_n : 13'd0;
        dur  <= (last_t >= first_t) ? last_t - first_t : 32'd0;
      end else begin
        expected <= 13'd0;
        lost <= 13'd0;
        dur <= 32'd0;
      end
    end
  end

  // dividers: fps, loss, jitter
  logic [63:0] q_fps, q_bp, q_jit, fps_num, nn;
  logic        d0, d1, d2;
  logic [45:0] lost_x;
  assign fps_num = 64'(delivered - 32'd1) * 64'd256000000;
  assign lost_x  = 46'(lost) * 46'd10000;
  assign nn      = 64'(n_lat) * 64'(n_lat);

  fssm_div u_div_fps (.clk, .rst, .start(cmd.div_start), .dividend(fps_num),
                      .divisor({32'd0, dur}), .done(d0), .quotient(q_fps));
  fssm_div u_div_bp  (.clk, .rst, .start(cmd.div_start), .dividend(64'(lost_x)),
                      .divisor(64'(expected)), .done(d1), .quotient(q_bp));
  fssm_div u_div_jit (.clk, .rst, .start(cmd.div_start), .dividend(64'(dev_acc)),
                      .divisor(nn), .done(d2), .quotient(q_jit));
  assign sts.div_done = d0 && d1 && d2;

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.delivered_count   <= delivered;
      result.unique_count      <= unique_n;
      result.lost_count        <= lost;
      result.corrupt_count     <= corrupt;
      result.duplicate_count   <= duplicate;
      result.reordered_count   <= reordered;
      result.duration_us       <= dur;
      result.fps_q8            <= (dur == 0 || delivered <= 32'd1) ? 32'd0 :
                                  (q_fps[63:32] != 0 ? 32'hFFFF_FFFF : q_fps[31:0]);
      result.loss_basis_points <= (expected == 0) ? 14'd0 : q_bp[13:0];
      result.jitter_us         <= (n_lat == 0) ? 33'd0 :
                                  (q_jit[63:33] != 0 ? '1 : q_jit[32:0]);
    end
  end
endmodule

[rtl/core/fssm_ctrl.sv]
// Controller state machine: bitmap clearing, frame update sequence and the
// snapshot walk/divide sequence. Depends on fssm_pkg.
module fssm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_req,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output fssm_pkg::cmd_t cmd,
  input  fssm_pkg::sts_t sts
);
  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_FRD, S_FUPD, S_SINIT, S_SUM, S_DEVI, S_DEV, S_DIVS, S_DIV,
    S_LOAD, S_OUT
  } state_t;
  state_t state;

  // state register with registered output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_CLR:   if (sts.clr_done) state <= S_IDLE;
        S_IDLE:  if (in_valid) state <= (in_req == fssm_pkg::REQ_SNAP) ? S_SINIT : S_FRD;
        S_FRD:   state <= S_FUPD;
        S_FUPD:  state <= S_IDLE;
        S_SINIT: state <= S_SUM;
        S_SUM:   if (sts.pipe_idle) state <= S_DEVI;
        S_DEVI:  state <= S_DEV;
        S_DEV:   if (sts.pipe_idle) state <= S_DIVS;
        S_DIVS:  state <= S_DIV;
        S_DIV:   if (sts.div_done) state <= S_LOAD;
        S_LOAD:  begin state <= S_OUT; out_valid <= 1'b1; end
        S_OUT:   if (out_ready) begin state <= S_IDLE; out_valid <= 1'b0; end
        default: state <= S_IDLE;
      endcase
    end
  end

  // input is held in the top register while the item is worked
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.clr_step  = (state == S_CLR) && !sts.clr_done;
    cmd.frm_rd    = (state == S_FRD);
    cmd.frm_upd   = (state == S_FUPD);
    cmd.snap_init = (state == S_SINIT);
    cmd.sum_step  = (state == S_SUM);
    cmd.dev_start = (state == S_DEVI);
    cmd.dev_step  = (state == S_DEV) || (state == S_DEVI);
    cmd.div_start = (state == S_DIVS);
    cmd.out_load  = (state == S_LOAD);
  end
endmodule

[rtl/core/frame_stream_statistics_monitor.sv]
// Frame stream statistics monitor, top level.
// Frame word: accepted, then bitmap read, then update.
// Snapshot: the result follows two ring walks over the n kept gaps, one read per
// cycle, and the three 64-step dividers; the next word is taken the cycle after
// the result leaves. One word at a time.
// Reset: synchronous; then a sweep clears the seen bitmap before a word is taken.
module frame_stream_statistics_monitor #(
  parameter int ID_BITS   = 12,
  parameter int GAP_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  fssm_in_if.sink     in_ch,
  fssm_out_if.source  out_ch
);
  fssm_pkg::cmd_t     cmd;
  fssm_pkg::sts_t     sts;
  fssm_pkg::in_word_t in_hold;
  logic [6:0]         gap_window;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) gap_window <= 7'd16;
    else if (cfg_we) gap_window <= cfg_wdata;
  end

  // capture the accepted word
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) in_hold <= in_ch.data;
  end

  fssm_ctrl u_ctrl (
    .clk, .rst, .in_valid(in_ch.valid), .in_req(in_ch.data.req_type),
    .in_ready(in_ch.ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd, .sts
  );

  fssm_dp #(.ID_BITS(ID_BITS), .GAP_DEPTH(GAP_DEPTH)) u_dp (
    .clk, .rst, .cmd, .sts, .in_word(in_hold), .gap_window, .result(out_ch.data)
  );
endmodule

[rtl/core/fssm_checks.sv]
// Port-level checks for the statistics monitor, bound to the top level.
// Depends on fssm_pkg and the channel interfaces.
module fssm_checks (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input fssm_pkg::out_word_t out_data
);
  // one word in flight: no input taken while a result waits
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken during result");
  // results held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data)) else $error("result changed");
  // a taken result is followed by idle output
  a_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid) else $error("result repeated");
  // loss never exceeds the whole
  a_bp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.loss_basis_points <= 14'd10000) else $error("loss range");
endmodule

bind frame_stream_statistics_monitor fssm_checks u_checks (
  .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
